FILE: rtl/core/smvm_pkg.sv
// ----------------------------------------------------------------------------
// smvm_pkg
// Shared types and constants of the square matrix times vector block.
// ----------------------------------------------------------------------------
package smvm_pkg;

    // Store geometry and number format.
    localparam int MAX_DIM    = 16;
    localparam int VALUE_BITS = 32;
    localparam int FRAC_BITS  = 16;

    localparam int IDX_BITS  = $clog2(MAX_DIM);
    localparam int ADDR_BITS = $clog2(MAX_DIM * MAX_DIM);
    localparam int PROD_BITS = 2 * VALUE_BITS;
    localparam int ACC_BITS  = PROD_BITS + IDX_BITS + 1;

    // Fixed widths of the word fields.
    localparam int CMD_BITS       = 2;
    localparam int FIELD_IDX_BITS = 4;
    localparam int ELEM_BITS      = 32;
    localparam int CFG_BITS       = 5;
    localparam int DIM_RESET      = 16;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_WR_MATRIX = 2'd0,
        CMD_WR_VECTOR = 2'd1,
        CMD_START     = 2'd2
    } t_cmd;

    // Control that travels with each matrix/vector read through the MAC pipe.
    typedef struct packed {
        logic                valid;
        logic                first;
        logic                last_col;
        logic                last_row;
        logic [IDX_BITS-1:0] row;
    } t_tag;

endpackage

FILE: rtl/core/smvm_ram.sv
// ----------------------------------------------------------------------------
// smvm_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module smvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read data holds while no read is requested.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/smvm_seq.sv
// ----------------------------------------------------------------------------
// smvm_seq
// Input decode, store writes and the row/column read sequencer.
// ----------------------------------------------------------------------------
module smvm_seq import smvm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [CMD_BITS-1:0]   i_cmd,
    input  logic [FIELD_IDX_BITS-1:0] i_row,
    input  logic [FIELD_IDX_BITS-1:0] i_col,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_cfg_we,
    input  logic [CFG_BITS-1:0]   i_cfg_wdata,
    input  logic                  i_adv,
    input  logic                  i_mac_busy,
    output logic                  o_mat_we,
    output logic [ADDR_BITS-1:0]  o_mat_waddr,
    output logic                  o_vec_we,
    output logic [IDX_BITS-1:0]   o_vec_waddr,
    output logic [VALUE_BITS-1:0] o_wdata,
    output logic                  o_rd_en,
    output logic [ADDR_BITS-1:0]  o_mat_raddr,
    output logic [IDX_BITS-1:0]   o_vec_raddr,
    output t_tag                  o_tag
);

    // Index of the last row/column in use; zero counts as one, large values clamp.
    function automatic logic [IDX_BITS-1:0] dim_last(input logic [CFG_BITS-1:0] v);
        logic [IDX_BITS-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (int'(v) > MAX_DIM) begin
            res = IDX_BITS'(MAX_DIM - 1);
        end else begin
            res = IDX_BITS'(int'(v) - 1);
        end
        return res;
    endfunction

    logic                r_busy;
    logic [IDX_BITS-1:0] r_row;
    logic [IDX_BITS-1:0] r_col;
    logic [IDX_BITS-1:0] r_dim_last;
    t_tag                r_tag;
    t_tag                n_tag;

    logic accept;
    logic start;
    logic issue;
    t_cmd cmd;

    // New words only while no multiply reads the stores.
    assign o_ready = !r_busy && !r_tag.valid && !i_mac_busy;
    assign accept  = i_valid && o_ready;
    assign cmd     = t_cmd'(i_cmd);

    always_comb begin
        o_mat_we = 1'b0;
        o_vec_we = 1'b0;
        start    = 1'b0;
        case (cmd)
            CMD_WR_MATRIX: begin
                o_mat_we = accept && (int'(i_row) < MAX_DIM) && (int'(i_col) < MAX_DIM);
            end
            CMD_WR_VECTOR: begin
                o_vec_we = accept && (int'(i_col) < MAX_DIM);
            end
            CMD_START: begin
                start = accept;
            end
            default: begin
                start = 1'b0;
            end
        endcase
    end

    assign o_mat_waddr = ADDR_BITS'(int'(i_row) * MAX_DIM + int'(i_col));
    assign o_vec_waddr = IDX_BITS'(i_col);
    assign o_wdata     = i_value;

    assign issue       = r_busy && i_adv;
    assign o_rd_en     = issue;
    assign o_mat_raddr = ADDR_BITS'(int'(r_row) * MAX_DIM + int'(r_col));
    assign o_vec_raddr = r_col;

    always_comb begin
        n_tag.valid    = issue;
        n_tag.first    = (r_col == '0);
        n_tag.last_col = (r_col == r_dim_last);
        n_tag.last_row = (r_row == r_dim_last);
        n_tag.row      = r_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_row      <= '0;
            r_col      <= '0;
            r_dim_last <= dim_last(CFG_BITS'(DIM_RESET));
            r_tag      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_dim_last <= dim_last(i_cfg_wdata);
            end
            if (start) begin
                r_busy <= 1'b1;
                r_row  <= '0;
                r_col  <= '0;
            end else if (issue) begin
                if (r_col == r_dim_last) begin
                    r_col <= '0;
                    if (r_row == r_dim_last) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (i_adv) begin
                r_tag <= n_tag;
            end
        end
    end

    assign o_tag = r_tag;

endmodule

FILE: rtl/core/smvm_mac.sv
// ----------------------------------------------------------------------------
// smvm_mac
// Multiply, full-width accumulate, saturating narrow and the result register.
// ----------------------------------------------------------------------------
module smvm_mac import smvm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_tag                  i_tag,
    input  logic [VALUE_BITS-1:0] i_mat_data,
    input  logic [VALUE_BITS-1:0] i_vec_data,
    input  logic                  i_out_ready,
    output logic                  o_adv,
    output logic                  o_busy,
    output logic                  o_out_valid,
    output logic [IDX_BITS-1:0]   o_out_row,
    output logic [VALUE_BITS-1:0] o_out_value,
    output logic                  o_out_sat,
    output logic                  o_out_last
);

    t_tag                        r_s2;
    logic signed [PROD_BITS-1:0] r_prod;
    logic signed [ACC_BITS-1:0]  r_acc;
    logic                        r_out_valid;
    logic [IDX_BITS-1:0]         r_out_row;
    logic [VALUE_BITS-1:0]       r_out_value;
    logic                        r_out_sat;
    logic                        r_out_last;

    logic signed [PROD_BITS-1:0] n_prod;
    logic signed [ACC_BITS-1:0]  n_acc;
    logic signed [ACC_BITS-1:0]  shifted;
    logic [ACC_BITS-VALUE_BITS:0] top;
    logic                        fits;
    logic [VALUE_BITS-1:0]       n_value;

    // The whole pipe moves only when the result register can take a word.
    assign o_adv  = !r_out_valid || i_out_ready;
    assign o_busy = r_s2.valid;

    assign n_prod  = $signed(i_mat_data) * $signed(i_vec_data);
    assign n_acc   = (r_s2.first ? ACC_BITS'(0) : r_acc) + ACC_BITS'(r_prod);
    assign shifted = n_acc >>> FRAC_BITS;
    assign top     = shifted[ACC_BITS-1:VALUE_BITS-1];
    assign fits    = (&top) || !(|top);

    always_comb begin
        if (fits) begin
            n_value = shifted[VALUE_BITS-1:0];
        end else if (n_acc[ACC_BITS-1]) begin
            n_value = {1'b1, {(VALUE_BITS-1){1'b0}}};
        end else begin
            n_value = {1'b0, {(VALUE_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_adv) begin
                r_s2   <= i_tag;
                r_prod <= n_prod;
                if (r_s2.valid) begin
                    r_acc <= n_acc;
                end
            end
            if (o_adv && r_s2.valid && r_s2.last_col) begin
                r_out_valid <= 1'b1;
                r_out_row   <= r_s2.row;
                r_out_value <= n_value;
                r_out_sat   <= !fits;
                r_out_last  <= r_s2.last_row;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_value = r_out_value;
    assign o_out_sat   = r_out_sat;
    assign o_out_last  = r_out_last;

endmodule

FILE: rtl/core/square_matrix_vector_multiply_top.sv
// ----------------------------------------------------------------------------
// square_matrix_vector_multiply_top
// Square matrix times vector in signed Q16.16 with a saturated result per row.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                     Content
// s_axis    in   s_axis_tvalid/s_axis_tready   command word: matrix or vector
//                                              element write, or start
// m_axis    out  m_axis_tvalid/m_axis_tready   one result word per row in use
// cfg       in   i_cfg_we                      dimension register write
//
// Element writes are accepted back to back.
// A start issues dimension*dimension store reads, one MAC per cycle while
// the result word is not stalled, bounded by the single read port of the
// matrix RAM; the last result passes the read, product and result registers.
// No input word is taken while a multiply reads the stores.
// A stalled result word freezes the whole MAC pipeline in place.
// Reset clears control only; the stores hold nothing defined until written.
//
module square_matrix_vector_multiply_top import smvm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input word.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // Fields from bit 0: row_index[3:0], column_index[7:4], element_value[39:8].
    input  logic [39:0]         s_axis_tdata,
    // Fields from bit 0: command[1:0].
    input  logic [1:0]          s_axis_tuser,
    // Result word.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // Fields from bit 0: result_row[3:0], result_value[35:4], zero fill [39:36].
    output logic [39:0]         m_axis_tdata,
    // Fields from bit 0: saturated[0].
    output logic [0:0]          m_axis_tuser,
    output logic                m_axis_tlast,
    // Dimension register.
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_wdata
);

    logic                  mat_we;
    logic [ADDR_BITS-1:0]  mat_waddr;
    logic                  vec_we;
    logic [IDX_BITS-1:0]   vec_waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic                  rd_en;
    logic [ADDR_BITS-1:0]  mat_raddr;
    logic [IDX_BITS-1:0]   vec_raddr;
    logic [VALUE_BITS-1:0] mat_rdata;
    logic [VALUE_BITS-1:0] vec_rdata;
    t_tag                  tag;
    logic                  adv;
    logic                  mac_busy;
    logic [IDX_BITS-1:0]   out_row;
    logic [VALUE_BITS-1:0] out_value;
    logic                  out_sat;

    // Only the low VALUE_BITS of the element field are stored.
    logic [VALUE_BITS-1:0] in_value;
    assign in_value = VALUE_BITS'(s_axis_tdata[39:8]);

    smvm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_row       (s_axis_tdata[3:0]),
        .i_col       (s_axis_tdata[7:4]),
        .i_value     (in_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (adv),
        .i_mac_busy  (mac_busy),
        .o_mat_we    (mat_we),
        .o_mat_waddr (mat_waddr),
        .o_vec_we    (vec_we),
        .o_vec_waddr (vec_waddr),
        .o_wdata     (wdata),
        .o_rd_en     (rd_en),
        .o_mat_raddr (mat_raddr),
        .o_vec_raddr (vec_raddr),
        .o_tag       (tag)
    );

    // Matrix entry row*MAX_DIM+column.
    smvm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_DIM * MAX_DIM)
    ) u_matrix_ram (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr (mat_waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (mat_raddr),
        .o_rdata (mat_rdata)
    );

    smvm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_DIM)
    ) u_vector_ram (
        .i_clk   (i_clk),
        .i_we    (vec_we),
        .i_waddr (vec_waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (vec_raddr),
        .o_rdata (vec_rdata)
    );

    smvm_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag       (tag),
        .i_mat_data  (mat_rdata),
        .i_vec_data  (vec_rdata),
        .i_out_ready (m_axis_tready),
        .o_adv       (adv),
        .o_busy      (mac_busy),
        .o_out_valid (m_axis_tvalid),
        .o_out_row   (out_row),
        .o_out_value (out_value),
        .o_out_sat   (out_sat),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, ELEM_BITS'(out_value), FIELD_IDX_BITS'(out_row)};
    assign m_axis_tuser = out_sat;

endmodule

FILE: rtl/core/smvm_checker.sv
// ----------------------------------------------------------------------------
// smvm_checker
// Port-level checks of the matrix times vector block, bound to the top level.
// ----------------------------------------------------------------------------
module smvm_checker import smvm_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A result word waits until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // A start locks out further words while the stores are read.
    a_start_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_START) |=> !s_axis_tready)
        else $error("word accepted during a multiply");

    // The fill bits above the result value are always zero.
    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39:36] == 4'b0000))
        else $error("fill bits of a result word are not zero");

endmodule

bind square_matrix_vector_multiply_top smvm_checker u_smvm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
